>>> hw/rtl/pet_pkg.sv
// Package for the procedure extent table: request and status codes and
// the result word shared by the core and its output register.
// No dependencies.
package pet_pkg;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BEYOND    = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [31:0] locals;
    logic [31:0] entry;
    logic [31:0] limit;
  } result_t;

endpackage

>>> hw/rtl/pet_out_reg.sv
// Output register of the procedure extent table: holds one result word
// until the receiver takes it. Depends on pet_pkg.
module pet_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  pet_pkg::result_t push_data,
  output logic            push_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output pet_pkg::result_t out_data
);

  logic full;

  // a held word may be replaced in the same cycle it is taken
  assign push_ready = !full || !out_stall;
  assign out_valid  = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push_ready) begin
      full <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      out_data <= push_data;
    end
  end

endmodule

>>> hw/rtl/procedure_extent_table_core.sv
// Procedure extent table core: descriptor tables in synchronous memories,
// add/read sequencer with a table walk, config register.
// Depends on pet_pkg and pet_out_reg.
//
// Usage:
//   Input channel (in_valid / in_stall): one word per request, req_type
//   selects add (0) or read (1). Output channel (out_valid / out_stall):
//   one result word per request, in order. Config channel
//   (cfg_valid / cfg_ready, always ready) writes text_end; write it only
//   while no request is in flight.
//   An add walks every stored entry through the memory read port, one
//   entry a cycle, cutting limits as it goes, then appends the new entry.
//   A read of a stored entry passes through the read state to the emit
//   state; a rejected add or a bad read index goes straight to emit. One
//   request is worked on at a time; the next is taken once the current
//   result sits in the output register, so a stalled receiver holds back
//   one further request.
//   Reset clears the entry count, text_end and the handshake state; the
//   table memories are not cleared and need no clearing pass, since only
//   entries below the count are ever read.
module procedure_extent_table_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [31:0] local_size,
  input  logic [31:0] entry_addr,
  input  logic [7:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  slot,
  output logic [31:0] out_locals,
  output logic [31:0] out_entry,
  output logic [31:0] out_limit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (CW > 8) ? CW : 8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]       state;
  logic [CW-1:0]    count;
  logic [31:0]      text_end;
  logic [AW-1:0]    proc;
  logic [31:0]      cur_ent;
  logic [31:0]      cur_loc;
  logic [31:0]      lim;
  pet_pkg::result_t res;

  // {entry, limit} per slot, and locals per slot
  logic [63:0] el_mem [TABLE_DEPTH];
  logic [31:0] loc_mem [TABLE_DEPTH];
  logic [63:0] el_rd;
  logic [31:0] loc_rd;

  logic [AW-1:0] rd_addr;
  logic          el_we;
  logic          loc_we;
  logic [AW-1:0] wr_addr;
  logic [63:0]   el_wd;

  logic [IW-1:0] count_w;
  logic [IW-1:0] idx_w;
  logic [31:0]   rd_ent;
  logic [31:0]   rd_lim;

  logic             push_valid;
  logic             push_ready;
  pet_pkg::result_t out_data;

  assign count_w   = IW'(count);
  assign idx_w     = IW'(read_index);
  assign rd_ent    = el_rd[63:32];
  assign rd_lim    = el_rd[31:0];
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign push_valid = (state == S_EMIT);

  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = proc + AW'(1);
    end else if (req_type == pet_pkg::REQ_READ) begin
      rd_addr = idx_w[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    el_we   = 1'b0;
    loc_we  = 1'b0;
    wr_addr = proc;
    el_wd   = {rd_ent, cur_ent};
    if (state == S_SCAN) begin
      // older entry that starts below and reaches past the new one
      el_we = (rd_ent < cur_ent) && (rd_lim > cur_ent);
    end else if (state == S_WRITE) begin
      el_we   = 1'b1;
      loc_we  = 1'b1;
      wr_addr = count[AW-1:0];
      el_wd   = {cur_ent, lim};
    end
  end

  always_ff @(posedge clk) begin
    el_rd  <= el_mem[rd_addr];
    loc_rd <= loc_mem[rd_addr];
    if (el_we) begin
      el_mem[wr_addr] <= el_wd;
    end
    if (loc_we) begin
      loc_mem[wr_addr] <= cur_loc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      text_end <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        text_end <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_ent <= entry_addr;
            cur_loc <= local_size;
            if (req_type == pet_pkg::REQ_READ) begin
              if (idx_w >= count_w) begin
                res   <= '{pet_pkg::ST_BAD_INDEX, read_index, 32'd0, 32'd0, 32'd0};
                state <= S_EMIT;
              end else begin
                res.slot <= read_index;
                state    <= S_READ;
              end
            end else if (entry_addr > text_end) begin
              res   <= '{pet_pkg::ST_BEYOND, count_w[7:0], 32'd0, 32'd0, 32'd0};
              state <= S_EMIT;
            end else if (count == CW'(TABLE_DEPTH)) begin
              res   <= '{pet_pkg::ST_FULL, count_w[7:0], 32'd0, 32'd0, 32'd0};
              state <= S_EMIT;
            end else begin
              lim   <= text_end;
              proc  <= '0;
              state <= (count == '0) ? S_WRITE : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // new limit falls to the lowest entry point above the new one
          if ((rd_ent > cur_ent) && (lim > rd_ent)) begin
            lim <= rd_ent;
          end
          if (CW'(proc) == count - CW'(1)) begin
            state <= S_WRITE;
          end else begin
            proc <= proc + AW'(1);
          end
        end
        S_WRITE: begin
          res   <= '{pet_pkg::ST_OK, count_w[7:0], cur_loc, cur_ent, lim};
          count <= count + CW'(1);
          state <= S_EMIT;
        end
        S_READ: begin
          res   <= '{pet_pkg::ST_OK, res.slot, loc_rd, rd_ent, rd_lim};
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (push_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  pet_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (res),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign status     = out_data.status;
  assign slot       = out_data.slot;
  assign out_locals = out_data.locals;
  assign out_entry  = out_data.entry;
  assign out_limit  = out_data.limit;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0) && (CW'(proc) < count))
    else $error("table walk past stored entries");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    el_we |-> (CW'(wr_addr) <= count) && (count < CW'(TABLE_DEPTH)))
    else $error("table write outside stored range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one in flight");
`endif

endmodule
